/* hw/rtl/hrp_pkg.sv */
package hrp_pkg;

    // payload buffer size in bytes, for each of the two banks
    localparam int MAX_DATA = 32;

    // offset into one bank, and the bank select bit on top of it
    localparam int OFS_W  = (MAX_DATA > 1) ? $clog2(MAX_DATA) : 1;
    localparam int BUF_AW = OFS_W + 1;
    localparam int BUF_DEPTH = 1 << BUF_AW;

    // data byte counter, able to hold MAX_DATA itself
    localparam int CNT_W = $clog2(MAX_DATA + 1);

    // record type bytes with rules of their own
    localparam logic [7:0] TYPE_DATA = 8'h00;
    localparam logic [7:0] TYPE_EOF  = 8'h01;
    localparam logic [7:0] TYPE_ELA  = 8'h04;

    typedef enum logic [2:0] {
        KIND_DATA,
        KIND_EOF,
        KIND_BASE,
        KIND_OTHER,
        KIND_ERROR
    } result_kind_t;

    typedef enum logic [2:0] {
        ERR_NONE,
        ERR_SHORT,
        ERR_CHECKSUM,
        ERR_LENGTH,
        ERR_FIELD,
        ERR_LONG
    } err_code_t;

    typedef enum logic [2:0] {
        JOB_DATA,
        JOB_EOF,
        JOB_BASE,
        JOB_OTHER,
        JOB_ERROR,
        JOB_CLEAR
    } job_kind_t;

    // one classified record, handed from front to back
    typedef struct packed {
        job_kind_t   kind;
        err_code_t   code;
        logic [7:0]  rec_type;
        logic [7:0]  count;
        logic [15:0] offset;
        logic [15:0] base;
        logic        bank;
    } job_t;

    typedef struct packed {
        logic              en;
        logic [BUF_AW-1:0] addr;
        logic [7:0]        data;
    } buf_wr_t;

    typedef struct packed {
        logic              en;
        logic [BUF_AW-1:0] addr;
    } buf_rd_t;

endpackage

/* hw/rtl/hrp_buf.sv */
module hrp_buf
    import hrp_pkg::*;
(
    input  logic       clk,
    input  buf_wr_t    wr,
    input  buf_rd_t    rd,
    output logic [7:0] rd_data
);

    logic [7:0] mem [BUF_DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr.en)
        begin
            mem[wr.addr] <= wr.data;
        end
    end

    // read data holds while no read is issued
    always_ff @(posedge clk)
    begin
        if (rd.en)
        begin
            rd_data <= mem[rd.addr];
        end
    end

endmodule

/* hw/rtl/hrp_queue.sv */
module hrp_queue
    import hrp_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic push,
    input  job_t push_job,
    input  logic pop,
    output job_t head,
    output logic empty,
    output logic full
);

    // two entries: one per payload bank
    localparam int Q_DEPTH = 2;
    localparam int PTR_W   = $clog2(Q_DEPTH);
    localparam int QCNT_W  = $clog2(Q_DEPTH + 1);

    job_t              entry_reg [Q_DEPTH];
    logic [PTR_W-1:0]  wr_ptr_reg;
    logic [PTR_W-1:0]  rd_ptr_reg;
    logic [QCNT_W-1:0] cnt_reg;

    assign head  = entry_reg[rd_ptr_reg];
    assign empty = (cnt_reg == '0);
    assign full  = (cnt_reg == QCNT_W'(Q_DEPTH));

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= push_job;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
            if (push && !pop)
            begin
                cnt_reg <= cnt_reg + 1'b1;
            end
            else if (pop && !push)
            begin
                cnt_reg <= cnt_reg - 1'b1;
            end
        end
    end

    a_no_push_full: assert property (@(posedge clk) disable iff (!rst_n)
        !(push && full))
        else $error("job pushed into a full queue");

    a_no_pop_empty: assert property (@(posedge clk) disable iff (!rst_n)
        !(pop && empty))
        else $error("job popped from an empty queue");

endmodule

/* hw/rtl/hrp_front.sv */
module hrp_front
    import hrp_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       req_valid,
    output logic       req_ready,
    input  logic       command,
    input  logic [7:0] record_byte,
    input  logic       last_byte,
    input  logic       q_full,
    output logic       job_push,
    output job_t       job,
    output buf_wr_t    buf_wr
);

    // byte positions of the record header
    localparam logic [8:0] POS_COUNT   = 9'd0;
    localparam logic [8:0] POS_ADDR_HI = 9'd1;
    localparam logic [8:0] POS_ADDR_LO = 9'd2;
    localparam logic [8:0] POS_TYPE    = 9'd3;
    localparam logic [8:0] POS_PAYLOAD = 9'd4;
    localparam logic [8:0] SEEN_MAX    = 9'd511;

    logic [8:0]  bytes_seen_reg;
    logic [7:0]  sum_reg;
    logic [7:0]  count_reg;
    logic [15:0] offset_reg;
    logic [7:0]  type_reg;
    logic        ovf_reg;
    logic [7:0]  base_hi_reg;
    logic [7:0]  base_lo_reg;
    logic        bank_reg;

    logic        accept;
    logic        record_end;
    logic [7:0]  sum_new;
    logic [8:0]  pay_idx;
    logic        stores;
    logic        in_range;
    logic        field_bad;
    err_code_t   err;

    assign req_ready  = !q_full;
    assign accept     = req_valid && req_ready;
    assign record_end = command || last_byte;

    assign sum_new  = sum_reg + record_byte;
    assign pay_idx  = bytes_seen_reg - POS_PAYLOAD;
    assign stores   = (type_reg == TYPE_DATA) || (type_reg == TYPE_ELA);
    assign in_range = (pay_idx < 9'(MAX_DATA));

    assign buf_wr.en   = accept && !record_end && (bytes_seen_reg >= POS_PAYLOAD)
                         && stores && in_range;
    assign buf_wr.addr = {bank_reg, pay_idx[OFS_W-1:0]};
    assign buf_wr.data = record_byte;

    always_comb
    begin
        field_bad = 1'b0;
        if (type_reg == TYPE_DATA && count_reg == 8'd0)
        begin
            field_bad = 1'b1;
        end
        if (type_reg == TYPE_EOF && (count_reg != 8'd0 || offset_reg != 16'd0))
        begin
            field_bad = 1'b1;
        end
        if (type_reg == TYPE_ELA && (count_reg != 8'd2 || offset_reg != 16'd0))
        begin
            field_bad = 1'b1;
        end

        if (bytes_seen_reg < POS_PAYLOAD)
        begin
            err = ERR_SHORT;
        end
        else if (sum_new != 8'd0)
        begin
            err = ERR_CHECKSUM;
        end
        else if (pay_idx != {1'b0, count_reg})
        begin
            err = ERR_LENGTH;
        end
        else if (ovf_reg)
        begin
            err = ERR_LONG;
        end
        else if (field_bad)
        begin
            err = ERR_FIELD;
        end
        else
        begin
            err = ERR_NONE;
        end
    end

    always_comb
    begin
        job.code     = command ? ERR_NONE : err;
        job.rec_type = type_reg;
        job.count    = count_reg;
        job.offset   = offset_reg;
        job.base     = {base_hi_reg, base_lo_reg};
        job.bank     = bank_reg;
        if (command)
        begin
            job.kind = JOB_CLEAR;
        end
        else if (err != ERR_NONE)
        begin
            job.kind = JOB_ERROR;
        end
        else if (type_reg == TYPE_DATA)
        begin
            job.kind = JOB_DATA;
        end
        else if (type_reg == TYPE_EOF)
        begin
            job.kind = JOB_EOF;
        end
        else if (type_reg == TYPE_ELA)
        begin
            job.kind = JOB_BASE;
        end
        else
        begin
            job.kind = JOB_OTHER;
        end
    end

    assign job_push = accept && record_end;

    // base bytes of an address record need no reset
    always_ff @(posedge clk)
    begin
        if (accept && !record_end && bytes_seen_reg >= POS_PAYLOAD && stores)
        begin
            if (pay_idx == 9'd0)
            begin
                base_hi_reg <= record_byte;
            end
            if (pay_idx == 9'd1)
            begin
                base_lo_reg <= record_byte;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            bytes_seen_reg <= '0;
            sum_reg        <= '0;
            count_reg      <= '0;
            offset_reg     <= '0;
            type_reg       <= '0;
            ovf_reg        <= 1'b0;
            bank_reg       <= 1'b0;
        end
        else if (accept)
        begin
            if (record_end)
            begin
                bytes_seen_reg <= '0;
                sum_reg        <= '0;
                count_reg      <= '0;
                offset_reg     <= '0;
                type_reg       <= '0;
                ovf_reg        <= 1'b0;
                bank_reg       <= !bank_reg;
            end
            else
            begin
                sum_reg <= sum_new;
                case (bytes_seen_reg)
                    POS_COUNT:   count_reg         <= record_byte;
                    POS_ADDR_HI: offset_reg[15:8]  <= record_byte;
                    POS_ADDR_LO: offset_reg[7:0]   <= record_byte;
                    POS_TYPE:    type_reg          <= record_byte;
                    default:
                    begin
                        if (stores && !in_range)
                        begin
                            ovf_reg <= 1'b1;
                        end
                    end
                endcase
                if (bytes_seen_reg != SEEN_MAX)
                begin
                    bytes_seen_reg <= bytes_seen_reg + 1'b1;
                end
            end
        end
    end

endmodule

/* hw/rtl/hrp_back.sv */
module hrp_back
    import hrp_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        q_empty,
    input  job_t        head,
    output logic        pop,
    output buf_rd_t     buf_rd,
    input  logic [7:0]  rd_data,
    output logic        rsp_valid,
    input  logic        rsp_ready,
    output logic [2:0]  result_kind,
    output logic [31:0] target_address,
    output logic [7:0]  payload_byte,
    output logic [7:0]  record_kind,
    output logic [7:0]  payload_count,
    output logic [2:0]  error_code,
    output logic        final_result
);

    typedef enum logic {
        ST_IDLE,
        ST_FETCH
    } state_t;

    state_t       state_reg;
    logic [15:0]  base_reg;
    logic [31:0]  addr_reg;
    logic [CNT_W-1:0] idx_reg;

    logic         rsp_valid_reg;
    result_kind_t kind_reg;
    logic [31:0]  target_reg;
    logic [7:0]   byte_reg;
    logic [7:0]   type_reg;
    logic [7:0]   count_reg;
    err_code_t    code_reg;
    logic         final_reg;

    logic         out_free;
    logic [CNT_W-1:0] idx_inc;
    logic         data_last;
    logic [31:0]  start_addr;
    result_kind_t notice_kind;

    assign out_free   = !rsp_valid_reg || rsp_ready;
    assign idx_inc    = idx_reg + 1'b1;
    assign data_last  = (idx_inc == head.count[CNT_W-1:0]);
    assign start_addr = {base_reg, 16'h0000} + {16'h0000, head.offset};

    always_comb
    begin
        case (head.kind)
            JOB_EOF:   notice_kind = KIND_EOF;
            JOB_BASE:  notice_kind = KIND_BASE;
            JOB_OTHER: notice_kind = KIND_OTHER;
            default:   notice_kind = KIND_ERROR;
        endcase
    end

    always_comb
    begin
        pop         = 1'b0;
        buf_rd.en   = 1'b0;
        buf_rd.addr = {head.bank, {OFS_W{1'b0}}};
        if (!q_empty)
        begin
            case (state_reg)
                ST_IDLE:
                begin
                    if (head.kind == JOB_CLEAR)
                    begin
                        pop = 1'b1;
                    end
                    else if (head.kind == JOB_DATA)
                    begin
                        buf_rd.en = 1'b1;
                    end
                    else
                    begin
                        pop = out_free;
                    end
                end
                ST_FETCH:
                begin
                    if (out_free)
                    begin
                        pop         = data_last;
                        buf_rd.en   = !data_last;
                        buf_rd.addr = {head.bank, idx_inc[OFS_W-1:0]};
                    end
                end
                default:
                begin
                    pop = 1'b0;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            base_reg      <= '0;
            addr_reg      <= '0;
            idx_reg       <= '0;
            rsp_valid_reg <= 1'b0;
            kind_reg      <= KIND_DATA;
            target_reg    <= '0;
            byte_reg      <= '0;
            type_reg      <= '0;
            count_reg     <= '0;
            code_reg      <= ERR_NONE;
            final_reg     <= 1'b0;
        end
        else
        begin
            if (rsp_ready)
            begin
                rsp_valid_reg <= 1'b0;
            end
            if (!q_empty)
            begin
                case (state_reg)
                    ST_IDLE:
                    begin
                        if (head.kind == JOB_CLEAR)
                        begin
                            base_reg <= '0;
                        end
                        else if (head.kind == JOB_DATA)
                        begin
                            idx_reg   <= '0;
                            addr_reg  <= start_addr;
                            state_reg <= ST_FETCH;
                        end
                        else if (out_free)
                        begin
                            rsp_valid_reg <= 1'b1;
                            kind_reg      <= notice_kind;
                            target_reg    <= (head.kind == JOB_BASE) ?
                                             {head.base, 16'h0000} : 32'h0;
                            byte_reg      <= 8'h00;
                            type_reg      <= head.rec_type;
                            count_reg     <= head.count;
                            code_reg      <= head.code;
                            final_reg     <= 1'b1;
                            if (head.kind == JOB_BASE)
                            begin
                                base_reg <= head.base;
                            end
                        end
                    end
                    ST_FETCH:
                    begin
                        if (out_free)
                        begin
                            rsp_valid_reg <= 1'b1;
                            kind_reg      <= KIND_DATA;
                            target_reg    <= addr_reg;
                            byte_reg      <= rd_data;
                            type_reg      <= head.rec_type;
                            count_reg     <= head.count;
                            code_reg      <= ERR_NONE;
                            final_reg     <= data_last;
                            addr_reg      <= addr_reg + 32'd1;
                            idx_reg       <= idx_inc;
                            if (data_last)
                            begin
                                state_reg <= ST_IDLE;
                            end
                        end
                    end
                    default:
                    begin
                        state_reg <= ST_IDLE;
                    end
                endcase
            end
        end
    end

    assign rsp_valid      = rsp_valid_reg;
    assign result_kind    = kind_reg;
    assign target_address = target_reg;
    assign payload_byte   = byte_reg;
    assign record_kind    = type_reg;
    assign payload_count  = count_reg;
    assign error_code     = code_reg;
    assign final_result   = final_reg;

    a_fetch_has_data_job: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_FETCH) |-> (!q_empty && head.kind == JOB_DATA))
        else $error("fetching payload without a data record at the queue head");

    a_error_has_code: assert property (@(posedge clk) disable iff (!rst_n)
        (rsp_valid_reg && kind_reg == KIND_ERROR) |-> (code_reg != ERR_NONE))
        else $error("error result without an error code");

endmodule

/* hw/rtl/hex_record_parser_unit.sv */
// Intel HEX record parser. Each request carries one binary record byte (count,
// address high, address low, type, payload, checksum) with last_byte set on the
// checksum byte, or, with command set, a parser reset that also clears the
// upper-16-bit linear base and produces no result. A front stage takes one
// request per cycle, keeps the running byte sum and header fields, stores data
// and address-record payload in one of two buffer banks, and at record end
// classifies the record into a job for a two-entry queue. A back stage works
// the jobs in order: a data record gives one result per payload byte at
// base + record address + offset, one per cycle while the output register
// is free, after a registered read of its buffer bank; every other record
// gives one result (end of file, base set, other type or error). Requests
// are taken at one per cycle as long as fewer than two records wait in the
// queue; once two records wait, req_ready stays low for every request until
// the back stage has finished the oldest record, since each queued record
// owns one buffer bank. Results sit in an output register, so the front keeps
// taking requests while a result waits on rsp_ready.
module hex_record_parser_unit
    import hrp_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,

    // request channel
    input  logic        req_valid,
    output logic        req_ready,
    input  logic        command,
    input  logic [7:0]  record_byte,
    input  logic        last_byte,

    // result channel
    output logic        rsp_valid,
    input  logic        rsp_ready,
    output logic [2:0]  result_kind,
    output logic [31:0] target_address,
    output logic [7:0]  payload_byte,
    output logic [7:0]  record_kind,
    output logic [7:0]  payload_count,
    output logic [2:0]  error_code,
    output logic        final_result
);

    // front to queue
    logic    job_push;
    job_t    push_job;

    // queue to back
    job_t    head_job;
    logic    q_empty;
    logic    q_full;
    logic    job_pop;

    // payload buffer ports
    buf_wr_t buf_wr;
    buf_rd_t buf_rd;
    logic [7:0] buf_rd_data;

    // header capture, checksum and record classification
    hrp_front u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .req_valid   (req_valid),
        .req_ready   (req_ready),
        .command     (command),
        .record_byte (record_byte),
        .last_byte   (last_byte),
        .q_full      (q_full),
        .job_push    (job_push),
        .job         (push_job),
        .buf_wr      (buf_wr)
    );

    // two banks, one per outstanding record
    hrp_buf u_buf (
        .clk     (clk),
        .wr      (buf_wr),
        .rd      (buf_rd),
        .rd_data (buf_rd_data)
    );

    // classified records waiting for the back stage
    hrp_queue u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (job_push),
        .push_job (push_job),
        .pop      (job_pop),
        .head     (head_job),
        .empty    (q_empty),
        .full     (q_full)
    );

    // result generation, base register and output register
    hrp_back u_back (
        .clk            (clk),
        .rst_n          (rst_n),
        .q_empty        (q_empty),
        .head           (head_job),
        .pop            (job_pop),
        .buf_rd         (buf_rd),
        .rd_data        (buf_rd_data),
        .rsp_valid      (rsp_valid),
        .rsp_ready      (rsp_ready),
        .result_kind    (result_kind),
        .target_address (target_address),
        .payload_byte   (payload_byte),
        .record_kind    (record_kind),
        .payload_count  (payload_count),
        .error_code     (error_code),
        .final_result   (final_result)
    );

endmodule
